// ===== hdl/sio_cfg_pkg.sv =====
// Shared types, constants and helpers of the Super I/O configuration register file.
// No dependencies; used by the register file, its checker and the whole testbench.
package sio_cfg_pkg;

   // Setting count: default and the largest value the 5-bit slot decode allows.
   localparam int unsigned NUM_SETTINGS_DEF = 25;
   localparam int unsigned NUM_SETTINGS_MAX = 32;

   // First index of the setting window.
   localparam logic [7:0] FIRST_INDEX = 8'hE0;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PORT_ENABLE   = 3'd0,
      CSR_FLOPPY_DMA    = 3'd1,
      CSR_FLOPPY_IRQ    = 3'd2,
      CSR_PARALLEL_IRQ  = 3'd3,
      CSR_SERIAL_A_IRQ  = 3'd4,
      CSR_SERIAL_B_IRQ  = 3'd5
   } csr_index_type;

   // Setting slots (offset from FIRST_INDEX).
   localparam logic [4:0] SLOT_ID_LOW     = 5'h00;
   localparam logic [4:0] SLOT_ID_HIGH    = 5'h01;
   localparam logic [4:0] SLOT_FUNC_EN    = 5'h02;
   localparam logic [4:0] SLOT_FLOPPY_IO  = 5'h03;
   localparam logic [4:0] SLOT_GAME_IO    = 5'h04;
   localparam logic [4:0] SLOT_REG_05     = 5'h05;
   localparam logic [4:0] SLOT_PAR_IO     = 5'h06;
   localparam logic [4:0] SLOT_SER_A_IO   = 5'h07;
   localparam logic [4:0] SLOT_SER_B_IO   = 5'h08;
   localparam logic [4:0] SLOT_REVISION   = 5'h0C;
   localparam logic [4:0] SLOT_REG_0D     = 5'h0D;
   localparam logic [4:0] SLOT_PWR_DOWN   = 5'h0F;
   localparam logic [4:0] SLOT_REG_10     = 5'h10;
   localparam logic [4:0] SLOT_REG_11     = 5'h11;
   localparam logic [4:0] SLOT_REG_13     = 5'h13;
   localparam logic [4:0] SLOT_REG_14     = 5'h14;
   localparam logic [4:0] SLOT_FLOPPY_CTL = 5'h16;
   localparam logic [4:0] SLOT_REG_17     = 5'h17;

   // Reset values of the nonzero settings.
   localparam logic [7:0] ID_LOW_RESET  = 8'h3C;
   localparam logic [7:0] FUNC_EN_RESET = 8'h03;

   // Parallel port legal window.
   localparam logic [9:0] PAR_BASE_MIN       = 10'h100;
   localparam logic [9:0] PAR_BASE_MAX_SPP   = 10'h3FC;
   localparam logic [9:0] PAR_BASE_MAX_EPP   = 10'h3F8;
   localparam logic [9:0] PAR_ALIGN_SPP      = 10'h3FC;
   localparam logic [9:0] PAR_ALIGN_EPP      = 10'h3F8;

   // Parallel mode field of the function enable setting.
   localparam logic [1:0] PAR_MODE_EPP  = 2'd2;
   localparam logic [1:0] PAR_MODE_OFF  = 2'd3;

   // One result.
   typedef struct packed {
      logic [7:0] read_data;
      logic       claimed;
      logic       floppy_on;
      logic [9:0] floppy_base;
      logic       floppy_swap;
      logic       parallel_on;
      logic [9:0] parallel_base;
      logic       parallel_epp;
      logic       serial_a_on;
      logic [9:0] serial_a_base;
      logic       serial_b_on;
      logic [9:0] serial_b_base;
   } rsp_type;

   // Per-setting write mask; settings not listed keep the byte as written.
   function automatic logic [7:0] mask_for(input logic [4:0] slot, input logic [7:0] v);
      logic [7:0] m;
      m = v;
      case (slot)
         SLOT_FUNC_EN:                       m = v & 8'hBF;
         SLOT_FLOPPY_IO, SLOT_GAME_IO:       m = v & 8'hFC;
         SLOT_REG_05:                        m = v | 8'h03;
         SLOT_SER_A_IO, SLOT_SER_B_IO,
         SLOT_REG_14, SLOT_REG_17:           m = v & 8'hFE;
         SLOT_REG_0D:                        m = v & 8'h0F;
         SLOT_PWR_DOWN:                      m = v & 8'h7F;
         SLOT_REG_10:                        m = v & 8'hF4;
         SLOT_REG_11:                        m = v & 8'h3F;
         SLOT_REG_13:                        m = v & 8'hFB;
         SLOT_FLOPPY_CTL:                    m = v & 8'hF7;
         default:                            m = v;
      endcase
      return m;
   endfunction

endpackage

// ===== hdl/superio_config_register_file.sv =====
// Super I/O index/data configuration register file with child-device decode.
// Depends on sio_cfg_pkg.
//
// Accepted into a free response register, a request raises rsp_valid the cycle after
// acceptance; else it waits in the skid. Throughput: one request per cycle while the skid
// is empty; the settings update and decode are one pass of logic between the request
// handshake and the response register, whose one-entry skid keeps req_stall registered.
// Reset (synchronous, active high): settings return to defaults, index and echo clear,
// port disabled, response and skid empty.
module superio_config_register_file #(
   parameter int unsigned NUM_SETTINGS = sio_cfg_pkg::NUM_SETTINGS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration write port
   input  logic                                csr_write_enable,
   input  logic [sio_cfg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sio_cfg_pkg::CSR_DATA_W-1:0]  csr_write_data,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic                                req_port_sel,
   input  logic [7:0]                          req_write_data,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_read_data,
   output logic                                rsp_claimed,
   output logic                                rsp_floppy_on,
   output logic [9:0]                          rsp_floppy_base,
   output logic                                rsp_floppy_swap,
   output logic                                rsp_parallel_on,
   output logic [9:0]                          rsp_parallel_base,
   output logic                                rsp_parallel_epp,
   output logic                                rsp_serial_a_on,
   output logic [9:0]                          rsp_serial_a_base,
   output logic                                rsp_serial_b_on,
   output logic [9:0]                          rsp_serial_b_base
);
   import sio_cfg_pkg::*;

   localparam int unsigned SLOT_W = $clog2(NUM_SETTINGS);

   // Architectural state.
   logic [7:0] settings_ff [NUM_SETTINGS];
   logic [7:0] settings_in [NUM_SETTINGS];
   logic [7:0] index_ff, index_in;
   logic [7:0] echo_ff, echo_in;
   // Only port_enable is stored and changes the responses; writes to the DMA/IRQ
   // configuration registers are not kept in this block.
   logic       port_enable_ff;

   // Response register and skid entry.
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   rsp_type    skid_ff, skid_in;

   logic       accept;
   logic       out_free;
   logic       in_range;
   logic [4:0] slot;
   logic       set_write;
   logic [7:0] set_wdata;
   rsp_type    result;

   // Decode temporaries (settings after the access)
   logic [7:0] s_func, s_pwr, s_par;
   logic       epp;
   logic [9:0] pbase;
   logic [9:0] plimit;

   assign accept   = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;
   assign out_free = !out_valid_ff || !rsp_stall;

   // Index window 0xE0..0xE0+NUM_SETTINGS-1: top three bits set, offset below the count.
   assign slot     = index_ff[4:0];
   assign in_range = (index_ff[7:5] == FIRST_INDEX[7:5]) &&
                     ({3'b000, slot} < 8'(NUM_SETTINGS));

   // Data-port write to a writable setting; ID bytes and revision are read-only.
   assign set_write = port_enable_ff && req_type && req_port_sel && in_range &&
                      (slot != SLOT_ID_LOW) && (slot != SLOT_ID_HIGH) &&
                      (slot != SLOT_REVISION);
   assign set_wdata = mask_for(slot, req_write_data);

   always_comb begin
      for (int i = 0; i < NUM_SETTINGS; i++) begin
         settings_in[i] = settings_ff[i];
         if (accept && set_write && (slot[SLOT_W-1:0] == SLOT_W'(i))) begin
            settings_in[i] = set_wdata;
         end
      end
   end

   // Index and echo: claimed accesses echo their byte, save data reads off the window.
   always_comb begin
      index_in = index_ff;
      echo_in  = echo_ff;
      if (accept && port_enable_ff) begin
         if (req_type) begin
            echo_in = req_write_data;
            if (!req_port_sel) begin
               index_in = req_write_data;
            end
         end else if (!req_port_sel) begin
            echo_in = index_ff;
         end else if (in_range) begin
            echo_in = settings_ff[slot[SLOT_W-1:0]];
         end
      end
   end

   // Child-device decode from the settings as they stand after the access.
   always_comb begin
      s_func = settings_in[SLOT_FUNC_EN[SLOT_W-1:0]];
      s_pwr  = settings_in[SLOT_PWR_DOWN[SLOT_W-1:0]];
      s_par  = settings_in[SLOT_PAR_IO[SLOT_W-1:0]];
      epp    = (s_func[1:0] == PAR_MODE_EPP);
      pbase  = {s_par, 2'b00} & (epp ? PAR_ALIGN_EPP : PAR_ALIGN_SPP);
      plimit = epp ? PAR_BASE_MAX_EPP : PAR_BASE_MAX_SPP;

      result.read_data     = echo_in;
      result.claimed       = port_enable_ff;
      result.floppy_on     = s_func[4] && (s_pwr[1:0] == 2'b00);
      result.floppy_base   = {settings_in[SLOT_FLOPPY_IO[SLOT_W-1:0]][7:2], 4'b0000};
      result.floppy_swap   = settings_in[SLOT_FLOPPY_CTL[SLOT_W-1:0]][0];
      result.parallel_on   = (s_func[1:0] != PAR_MODE_OFF) && !s_pwr[4] && !s_pwr[0] &&
                             (pbase >= PAR_BASE_MIN) && (pbase <= plimit);
      result.parallel_base = pbase;
      result.parallel_epp  = epp;
      // serial A: enable bit 2, powered down by bit 0 or bit 2
      result.serial_a_on   = s_func[2] && !s_pwr[0] && !s_pwr[2];
      result.serial_a_base = {settings_in[SLOT_SER_A_IO[SLOT_W-1:0]], 2'b00};
      // serial B: enable bit 3, powered down by bit 0 or bit 3
      result.serial_b_on   = s_func[3] && !s_pwr[0] && !s_pwr[3];
      result.serial_b_base = {settings_in[SLOT_SER_B_IO[SLOT_W-1:0]], 2'b00};
   end

   // Response register plus skid. A request is only accepted while the skid is empty.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_valid_in = 1'b1;
            out_in       = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SETTINGS; i++) begin
            if (i == int'(SLOT_ID_LOW)) begin
               settings_ff[i] <= ID_LOW_RESET;
            end else if (i == int'(SLOT_FUNC_EN)) begin
               settings_ff[i] <= FUNC_EN_RESET;
            end else begin
               settings_ff[i] <= 8'h00;
            end
         end
         index_ff       <= 8'h00;
         echo_ff        <= 8'h00;
         port_enable_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         settings_ff   <= settings_in;
         index_ff      <= index_in;
         echo_ff       <= echo_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (csr_write_enable && (csr_index == CSR_PORT_ENABLE)) begin
            port_enable_ff <= csr_write_data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_read_data     = out_ff.read_data;
   assign rsp_claimed       = out_ff.claimed;
   assign rsp_floppy_on     = out_ff.floppy_on;
   assign rsp_floppy_base   = out_ff.floppy_base;
   assign rsp_floppy_swap   = out_ff.floppy_swap;
   assign rsp_parallel_on   = out_ff.parallel_on;
   assign rsp_parallel_base = out_ff.parallel_base;
   assign rsp_parallel_epp  = out_ff.parallel_epp;
   assign rsp_serial_a_on   = out_ff.serial_a_on;
   assign rsp_serial_a_base = out_ff.serial_a_base;
   assign rsp_serial_b_on   = out_ff.serial_b_on;
   assign rsp_serial_b_base = out_ff.serial_b_base;

endmodule

// ===== hdl/sio_cfg_checker.sv =====
// Port-level checks for superio_config_register_file, bound into that module.
// Depends on sio_cfg_pkg.
module sio_cfg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                csr_write_enable,
   input logic [sio_cfg_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [sio_cfg_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [7:0]                          rsp_read_data,
   input logic                                rsp_claimed
);
   import sio_cfg_pkg::*;

   // Port enable as last written on the configuration port.
   logic port_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_enable_ff <= 1'b0;
      end else if (csr_write_enable && (csr_index == CSR_PORT_ENABLE)) begin
         port_enable_ff <= csr_write_data[0];
      end
   end

   // Response held while stalled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_claimed))
      else $error("response dropped or changed while stalled");

   // The request side only stalls with a response pending.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   // An accepted request into an empty output shows up in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> rsp_valid)
      else $error("accepted request produced no response");

   // Claimed follows the port enable, which the user must write only while idle; the block does not enforce this.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_claimed == port_enable_ff))
      else $error("claimed does not match the port enable");

endmodule

bind superio_config_register_file sio_cfg_checker u_sio_cfg_checker (
   .clock            (clock),
   .reset            (reset),
   .csr_write_enable (csr_write_enable),
   .csr_index        (csr_index),
   .csr_write_data   (csr_write_data),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_read_data    (rsp_read_data),
   .rsp_claimed      (rsp_claimed)
);

// ===== verif/sio_cfg_tb_pkg.sv =====
// Scoreboard for the Super I/O configuration register file testbench: access predictor
// and in-order response checker. Depends on sio_cfg_pkg for the response type and constants.
package sio_cfg_tb_pkg;
   import sio_cfg_pkg::*;

   // Request field codes
   localparam logic ACCESS_READ  = 1'b0;
   localparam logic ACCESS_WRITE = 1'b1;
   localparam logic PORT_INDEX   = 1'b0;
   localparam logic PORT_DATA    = 1'b1;

   class sio_access_scoreboard;
      logic [7:0] cfg_regs [NUM_SETTINGS_MAX];
      logic [7:0] index_reg;
      logic [7:0] echo_reg;
      logic       port_en;
      logic [1:0] floppy_dma;
      logic [3:0] floppy_irq, par_irq, ser_a_irq, ser_b_irq;
      rsp_type    expected_responses [$];
      int unsigned error_count, request_count, claimed_count, response_count;

      function new();
         foreach (cfg_regs[i]) cfg_regs[i] = '0;
         cfg_regs[SLOT_ID_LOW]  = ID_LOW_RESET;
         cfg_regs[SLOT_FUNC_EN] = FUNC_EN_RESET;
         index_reg  = '0;
         echo_reg   = '0;
         port_en    = 1'b0;
         floppy_dma = 2'd2;
         floppy_irq = '0;
         par_irq    = '0;
         ser_a_irq  = '0;
         ser_b_irq  = '0;
         error_count    = 0;
         request_count  = 0;
         claimed_count  = 0;
         response_count = 0;
      endfunction

      function void write_register(csr_index_type sel, logic [CSR_DATA_W-1:0] value);
         case (sel)
            CSR_PORT_ENABLE:  port_en    = value[0];
            CSR_FLOPPY_DMA:   floppy_dma = value[1:0];
            CSR_FLOPPY_IRQ:   floppy_irq = value;
            CSR_PARALLEL_IRQ: par_irq    = value;
            CSR_SERIAL_A_IRQ: ser_a_irq  = value;
            CSR_SERIAL_B_IRQ: ser_b_irq  = value;
            default: ;
         endcase
      endfunction

      // Setting selected by the index register, if it lies in the window
      function bit lookup_slot(output logic [4:0] slot);
         logic [7:0] offset;
         offset = index_reg - FIRST_INDEX;
         slot = offset[4:0];
         return index_reg >= FIRST_INDEX && offset < NUM_SETTINGS_DEF;
      endfunction

      function logic [7:0] masked_byte(logic [4:0] slot, logic [7:0] v);
         case (slot)
            SLOT_FUNC_EN:                   return v & 8'hBF;
            SLOT_FLOPPY_IO, SLOT_GAME_IO:   return v & 8'hFC;
            SLOT_REG_05:                    return v | 8'h03;
            SLOT_SER_A_IO, SLOT_SER_B_IO,
            SLOT_REG_14, SLOT_REG_17:       return v & 8'hFE;
            SLOT_REG_0D:                    return v & 8'h0F;
            SLOT_PWR_DOWN:                  return v & 8'h7F;
            SLOT_REG_10:                    return v & 8'hF4;
            SLOT_REG_11:                    return v & 8'h3F;
            SLOT_REG_13:                    return v & 8'hFB;
            SLOT_FLOPPY_CTL:                return v & 8'hF7;
            default:                        return v;
         endcase
      endfunction

      // Apply one accepted access and queue the response it must produce
      function void note_request(logic kind, logic port, logic [7:0] wdata);
         rsp_type    want;
         logic [4:0] slot;
         bit         in_window;
         logic [7:0] s2, s15;
         logic       epp;
         logic [9:0] pbase;

         request_count++;
         if (port_en) begin
            claimed_count++;
            in_window = lookup_slot(slot);
            if (kind == ACCESS_WRITE) begin
               echo_reg = wdata;
               if (port == PORT_INDEX) begin
                  index_reg = wdata;
               end else if (in_window && slot != SLOT_ID_LOW && slot != SLOT_ID_HIGH &&
                            slot != SLOT_REVISION) begin
                  cfg_regs[slot] = masked_byte(slot, wdata);
               end
            end else begin
               if (port == PORT_INDEX) begin
                  echo_reg = index_reg;
               end else if (in_window) begin
                  echo_reg = cfg_regs[slot];
               end
            end
         end

         s2    = cfg_regs[SLOT_FUNC_EN];
         s15   = cfg_regs[SLOT_PWR_DOWN];
         epp   = s2[1:0] == PAR_MODE_EPP;
         pbase = {cfg_regs[SLOT_PAR_IO], 2'b00} & (epp ? PAR_ALIGN_EPP : PAR_ALIGN_SPP);

         want.read_data     = echo_reg;
         want.claimed       = port_en;
         want.floppy_on     = s2[4] && s15[1:0] == 2'b00;
         want.floppy_base   = {cfg_regs[SLOT_FLOPPY_IO][7:2], 4'b0000};
         want.floppy_swap   = cfg_regs[SLOT_FLOPPY_CTL][0];
         want.parallel_on   = s2[1:0] != PAR_MODE_OFF && (s15 & 8'h11) == 8'h00 &&
                              pbase >= PAR_BASE_MIN &&
                              pbase <= (epp ? PAR_BASE_MAX_EPP : PAR_BASE_MAX_SPP);
         want.parallel_base = pbase;
         want.parallel_epp  = epp;
         want.serial_a_on   = s2[2] && !s15[0] && !s15[2];
         want.serial_a_base = {cfg_regs[SLOT_SER_A_IO], 2'b00};
         want.serial_b_on   = s2[3] && !s15[0] && !s15[3];
         want.serial_b_base = {cfg_regs[SLOT_SER_B_IO], 2'b00};
         expected_responses.push_back(want);
      endfunction

      function void compare_field(string name, logic [9:0] want, logic [9:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_responses.size() == 0) begin
            $error("response arrived with no request outstanding");
            error_count++;
            return;
         end
         want = expected_responses.pop_front();
         response_count++;
         compare_field("read_data",     10'(want.read_data),    10'(got.read_data));
         compare_field("claimed",       10'(want.claimed),      10'(got.claimed));
         compare_field("floppy_on",     10'(want.floppy_on),    10'(got.floppy_on));
         compare_field("floppy_base",   want.floppy_base,       got.floppy_base);
         compare_field("floppy_swap",   10'(want.floppy_swap),  10'(got.floppy_swap));
         compare_field("parallel_on",   10'(want.parallel_on),  10'(got.parallel_on));
         compare_field("parallel_base", want.parallel_base,     got.parallel_base);
         compare_field("parallel_epp",  10'(want.parallel_epp), 10'(got.parallel_epp));
         compare_field("serial_a_on",   10'(want.serial_a_on),  10'(got.serial_a_on));
         compare_field("serial_a_base", want.serial_a_base,     got.serial_a_base);
         compare_field("serial_b_on",   10'(want.serial_b_on),  10'(got.serial_b_on));
         compare_field("serial_b_base", want.serial_b_base,     got.serial_b_base);
      endfunction

      function void check_drained();
         if (expected_responses.size() != 0) begin
            $error("%0d responses never arrived", expected_responses.size());
            error_count++;
         end
      endfunction
   endclass

endpackage

// ===== verif/testbench.sv =====
// Top-level testbench of superio_config_register_file: directed and random bus accesses
// under varied idle/stall patterns, checked in order by the scoreboard of sio_cfg_tb_pkg.
// Depends on sio_cfg_pkg, sio_cfg_tb_pkg and the RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sio_cfg_pkg::*;
   import sio_cfg_tb_pkg::*;

   localparam int unsigned LONG_HOLD_CYCLES = 48;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // All block inputs start at known values
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;
   logic                   req_valid        = 1'b0;
   logic                   req_type         = ACCESS_READ;
   logic                   req_port_sel     = PORT_INDEX;
   logic [7:0]             req_write_data   = '0;
   logic                   rsp_stall        = 1'b0;

   logic       req_stall, rsp_valid;
   logic [7:0] rsp_read_data;
   logic       rsp_claimed, rsp_floppy_on, rsp_floppy_swap, rsp_parallel_on, rsp_parallel_epp;
   logic       rsp_serial_a_on, rsp_serial_b_on;
   logic [9:0] rsp_floppy_base, rsp_parallel_base, rsp_serial_a_base, rsp_serial_b_base;
   rsp_type    observed_rsp;

   // Traffic shaping, changed by the main sequence between phases
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   bit          long_hold_pending  = 1'b0;

   sio_access_scoreboard sb;

   always #10 clock = ~clock;

   superio_config_register_file i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_port_sel      (req_port_sel),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_claimed       (rsp_claimed),
      .rsp_floppy_on     (rsp_floppy_on),
      .rsp_floppy_base   (rsp_floppy_base),
      .rsp_floppy_swap   (rsp_floppy_swap),
      .rsp_parallel_on   (rsp_parallel_on),
      .rsp_parallel_base (rsp_parallel_base),
      .rsp_parallel_epp  (rsp_parallel_epp),
      .rsp_serial_a_on   (rsp_serial_a_on),
      .rsp_serial_a_base (rsp_serial_a_base),
      .rsp_serial_b_on   (rsp_serial_b_on),
      .rsp_serial_b_base (rsp_serial_b_base)
   );

   assign observed_rsp = '{read_data:     rsp_read_data,
                           claimed:       rsp_claimed,
                           floppy_on:     rsp_floppy_on,
                           floppy_base:   rsp_floppy_base,
                           floppy_swap:   rsp_floppy_swap,
                           parallel_on:   rsp_parallel_on,
                           parallel_base: rsp_parallel_base,
                           parallel_epp:  rsp_parallel_epp,
                           serial_a_on:   rsp_serial_a_on,
                           serial_a_base: rsp_serial_a_base,
                           serial_b_on:   rsp_serial_b_on,
                           serial_b_base: rsp_serial_b_base};

   // Monitor: all block inputs and outputs change by NBA, so reading them here gives the
   // values the block saw at this edge. Register writes land before any request at the same
   // edge could (writes only happen while idle), and requests are noted before responses.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable)
            sb.write_register(csr_index_type'(csr_index), csr_write_data);
         if (req_valid && !req_stall)
            sb.note_request(req_type, req_port_sel, req_write_data);
         if (rsp_valid && !rsp_stall)
            sb.check_response(observed_rsp);
      end
   end

   // Receiver: random stall per cycle; on request, a long hold-off counted here so the
   // block backs up and stalls its request side while the sender keeps offering.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= $urandom_range(99) < receiver_stall_pct;
         end
      end
   end

   // Offer one request (after an optional random gap) and hold it until accepted.
   // Valid stays high between back-to-back requests; one NBA per signal per step.
   task automatic send_request(input logic kind, input logic port, input logic [7:0] wdata);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_port_sel   <= port;
      req_write_data <= wdata;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Wait until every queued response has been returned
   task automatic wait_idle();
      do @(posedge clock); while (sb.expected_responses.size() != 0);
   endtask

   // Write all six registers back to back, holding the write enable across them
   task automatic load_registers(input logic [3:0] enable, input logic [3:0] dma,
                                 input logic [3:0] fdc_irq, input logic [3:0] lpt_irq,
                                 input logic [3:0] uart_a_irq, input logic [3:0] uart_b_irq);
      csr_index_type sel;
      logic [3:0]    values [6];
      values = '{enable, dma, fdc_irq, lpt_irq, uart_a_irq, uart_b_irq};
      sel = sel.first();
      repeat (sel.num()) begin
         csr_write_enable <= 1'b1;
         csr_index        <= sel;
         csr_write_data   <= values[int'(sel)];
         @(posedge clock);
         sel = sel.next();
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_random_registers(input logic [3:0] enable);
      load_registers(enable, 4'($urandom_range(3)), 4'($urandom_range(15)),
                     4'($urandom_range(15)), 4'($urandom_range(15)),
                     4'($urandom_range(15)));
   endtask

   // Mostly indexes inside the setting window, sometimes anywhere
   function automatic logic [7:0] pick_index();
      if ($urandom_range(99) < 85)
         return FIRST_INDEX + 8'($urandom_range(NUM_SETTINGS_DEF - 1));
      return 8'($urandom);
   endfunction

   // Data bytes biased toward all-zeros and all-ones
   function automatic logic [7:0] pick_data();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 15) return 8'h00;
      if (roll < 30) return 8'hFF;
      return 8'($urandom);
   endfunction

   // Random traffic: mostly index-then-data sequences, the rest arbitrary accesses
   task automatic send_random(input int unsigned count);
      int unsigned sent, run_len;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 75) begin
            send_request(ACCESS_WRITE, PORT_INDEX, pick_index());
            run_len = $urandom_range(1, 3);
            repeat (run_len) send_request(1'($urandom_range(1)), PORT_DATA, pick_data());
            sent += run_len + 1;
         end else begin
            send_request(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom));
            sent++;
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic set_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
   endtask

   // Directed accesses: window edges, read-only settings, out-of-range indexes, extremes
   task automatic send_directed();
      send_request(ACCESS_READ,  PORT_INDEX, 8'hFF);   // write data ignored on a read
      send_request(ACCESS_WRITE, PORT_INDEX, 8'hFF);   // index far out of range
      send_request(ACCESS_WRITE, PORT_DATA,  8'hAA);   // only the echo moves
      send_request(ACCESS_READ,  PORT_DATA,  8'h00);   // echo comes back unchanged
      send_request(ACCESS_WRITE, PORT_INDEX, 8'hDF);   // just below the window
      send_request(ACCESS_READ,  PORT_DATA,  8'h00);
      send_request(ACCESS_WRITE, PORT_INDEX, 8'hF9);   // just above the window
      send_request(ACCESS_WRITE, PORT_DATA,  8'h00);
      send_request(ACCESS_WRITE, PORT_INDEX, 8'hF8);   // last setting
      send_request(ACCESS_WRITE, PORT_DATA,  8'hFF);
      send_request(ACCESS_READ,  PORT_DATA,  8'h00);
      send_request(ACCESS_WRITE, PORT_INDEX, FIRST_INDEX);   // read-only ID byte
      send_request(ACCESS_WRITE, PORT_DATA,  8'h00);
      send_request(ACCESS_READ,  PORT_DATA,  8'hFF);
      send_request(ACCESS_WRITE, PORT_INDEX, FIRST_INDEX + 8'(SLOT_REVISION));   // read-only
      send_request(ACCESS_WRITE, PORT_DATA,  8'hFF);
      send_request(ACCESS_READ,  PORT_DATA,  8'h00);
      send_request(ACCESS_WRITE, PORT_INDEX, FIRST_INDEX + 8'(SLOT_FUNC_EN));
      send_request(ACCESS_WRITE, PORT_DATA,  8'h1E);   // floppy, both serials, EPP mode
      send_request(ACCESS_WRITE, PORT_INDEX, FIRST_INDEX + 8'(SLOT_PAR_IO));
      send_request(ACCESS_WRITE, PORT_DATA,  8'hFF);   // EPP base at its upper limit
      send_request(ACCESS_WRITE, PORT_INDEX, FIRST_INDEX + 8'(SLOT_SER_A_IO));
      send_request(ACCESS_WRITE, PORT_DATA,  8'hFF);
      send_request(ACCESS_WRITE, PORT_INDEX, FIRST_INDEX + 8'(SLOT_FLOPPY_IO));
      send_request(ACCESS_WRITE, PORT_DATA,  8'hFF);
      send_request(ACCESS_READ,  PORT_INDEX, 8'h00);
      req_valid <= 1'b0;
   endtask

   // Main sequence
   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Port still disabled after reset: accesses are not claimed and change nothing
      send_request(ACCESS_WRITE, PORT_INDEX, FIRST_INDEX + 8'(SLOT_FUNC_EN));
      send_request(ACCESS_READ,  PORT_DATA,  8'h00);
      req_valid <= 1'b0;
      wait_idle();

      load_registers(4'd1, 4'd0, 4'd15, 4'd15, 4'd15, 4'd15);
      send_directed();
      wait_idle();

      // Back to back, no idling on either side
      load_registers(4'd1, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0);
      send_random(215);
      wait_idle();

      // Port disabled again with random traffic
      load_random_registers(4'd0);
      set_traffic(30, 30);
      send_random(40);
      wait_idle();

      // Sparse sender
      load_random_registers(4'd1);
      set_traffic(88, 0);
      send_random(215);
      wait_idle();

      // Heavily stalling receiver
      load_random_registers(4'd1);
      set_traffic(0, 88);
      send_random(215);
      wait_idle();

      // Both sides idle now and then
      load_random_registers(4'd1);
      set_traffic(30, 30);
      send_random(215);
      wait_idle();

      // Back-pressure: long receiver hold-offs while the sender never pauses
      load_registers(4'd1, 4'd2, 4'd15, 4'd0, 4'd15, 4'd0);
      set_traffic(0, 0);
      long_hold_pending = 1'b1;
      send_random(100);
      long_hold_pending = 1'b1;
      send_random(115);
      wait_idle();

      repeat (4) @(posedge clock);
      sb.check_drained();

      $display("Covered %0d requests (%0d claimed by the port), %0d responses checked,",
               sb.request_count, sb.claimed_count, sb.response_count);
      $display("over eight traffic phases including back-pressure and disabled-port runs.");
      if (sb.error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #5ms;
      $display("testbench failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/sio_cfg_pkg.sv
hdl/superio_config_register_file.sv
hdl/sio_cfg_checker.sv
verif/sio_cfg_tb_pkg.sv
verif/testbench.sv
